// ----- rtl/core/rdpd_pkg.sv -----
// Shared types and constants for the rotary dial pulse decoder.
// Holds the configuration record, register indexes and reset values.
// No dependencies.
package rdpd_pkg;

	localparam int WAIT_W   = 16;
	localparam int LIM_W    = 6;
	localparam int DEB_W    = 10;
	localparam int PCNT_W   = 8;
	localparam int DIGIT_W  = 4;
	localparam int POS_W    = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int RESULT_LIMIT        = 32;
	localparam int DEF_MAX_DIGIT_STORE = 32;

	localparam logic [CFG_IDX_W-1:0] REG_WAITING_TIME = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DIGITS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE_INV   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_INV    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd4;

	localparam logic [WAIT_W-1:0] RST_WAITING_TIME = 16'd3000;
	localparam logic [LIM_W-1:0]  RST_MAX_DIGITS   = 6'd7;
	localparam logic [DEB_W-1:0]  RST_DEBOUNCE     = 10'd20;

	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	localparam logic [PCNT_W-1:0] PCNT_MAX   = 8'd255;
	localparam logic [PCNT_W-1:0] DIGIT_BASE = 8'd10;
	localparam logic [WAIT_W-1:0] IDLE_MAX   = 16'hFFFF;

	typedef struct packed {
		logic [WAIT_W-1:0] waiting_time_ms;
		logic [LIM_W-1:0]  max_digits;
		logic              enable_inverse;
		logic              pulse_inverse;
		logic [DEB_W-1:0]  debounce_ms;
	} cfg_t;

endpackage

// ----- rtl/core/rdpd_regs.sv -----
// Configuration register file of the rotary dial pulse decoder.
// Depends on rdpd_pkg for the register indexes, widths and reset values.
module rdpd_regs import rdpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.waiting_time_ms <= RST_WAITING_TIME;
			cfg_q.max_digits      <= RST_MAX_DIGITS;
			cfg_q.enable_inverse  <= 1'b0;
			cfg_q.pulse_inverse   <= 1'b0;
			cfg_q.debounce_ms     <= RST_DEBOUNCE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WAITING_TIME: cfg_q.waiting_time_ms <= cfg_data[WAIT_W-1:0];
				REG_MAX_DIGITS:   cfg_q.max_digits      <= cfg_data[LIM_W-1:0];
				REG_ENABLE_INV:   cfg_q.enable_inverse  <= cfg_data[0];
				REG_PULSE_INV:    cfg_q.pulse_inverse   <= cfg_data[0];
				REG_DEBOUNCE:     cfg_q.debounce_ms     <= cfg_data[DEB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/rdpd_store.sv -----
// Digit store of the rotary dial pulse decoder: one write port, one registered read port.
// Depends on rdpd_pkg for the digit width.
module rdpd_store import rdpd_pkg::*; #(
	parameter int DEPTH = DEF_MAX_DIGIT_STORE,
	parameter int AW    = 5
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [DIGIT_W-1:0] wdata,
	input  logic [AW-1:0]      raddr,
	output logic [DIGIT_W-1:0] rdata
);

	logic [DIGIT_W-1:0] mem [DEPTH];
	logic [DIGIT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/rdpd_ctrl.sv -----
// Tick processing and report sequencer of the rotary dial pulse decoder.
// Depends on rdpd_pkg; drives the write and read ports of rdpd_store.
module rdpd_ctrl import rdpd_pkg::*; #(
	parameter int CAP = RESULT_LIMIT,
	parameter int AW  = 5,
	parameter int CW  = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic               enable_level,
	input  logic               pulse_level,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [DIGIT_W-1:0] digit,
	output logic [POS_W-1:0]   digit_position,
	output logic               last_digit,
	output logic               st_we,
	output logic [AW-1:0]      st_waddr,
	output logic [DIGIT_W-1:0] st_wdata,
	output logic [AW-1:0]      st_raddr,
	input  logic [DIGIT_W-1:0] st_rdata
);

	localparam int CMP_W = LIM_W + 1;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;
	localparam logic [LIM_W-1:0] CAP_L = LIM_W'(CAP);

	logic [1:0]        state_q;
	logic              prev_en_q;
	logic              prev_pul_q;
	logic              dialing_q;
	logic [PCNT_W-1:0] pcnt_q;
	logic [CW-1:0]     count_q;
	logic [WAIT_W-1:0] idle_q;
	logic [DEB_W-1:0]  deb_q;
	logic [CW-1:0]     emit_n_q;
	logic [CW-1:0]     k_q;
	logic              out_valid_q;
	logic [DIGIT_W-1:0] digit_q;
	logic [POS_W-1:0]  pos_q;
	logic              last_q;

	logic              accept;
	logic [LIM_W-1:0]  limit;
	logic [CMP_W-1:0]  limit_x;
	logic [CMP_W-1:0]  count_x;
	logic [CMP_W-1:0]  count_n_x;
	logic              dial_en;
	logic              en_edge;
	logic              start;
	logic              commit;
	logic              report;
	logic              room;
	logic [WAIT_W-1:0] idle_n;
	logic              dial_n;
	logic [PCNT_W-1:0] pcnt_mid;
	logic [PCNT_W-1:0] pcnt_n;
	logic [CW-1:0]     count_n;
	logic [DEB_W-1:0]  deb_n;
	logic [CMP_W-1:0]  k_x;
	logic [CW-1:0]     k_inc;
	logic              k_last;
	logic              out_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		if (cfg.max_digits == '0) begin
			limit = LIM_W'(1);
		end else if (cfg.max_digits > CAP_L) begin
			limit = CAP_L;
		end else begin
			limit = cfg.max_digits;
		end
	end
	assign limit_x = CMP_W'(limit);
	assign count_x = CMP_W'(count_q);

	always_comb begin
		dial_en = ~enable_level ^ cfg.enable_inverse;
		en_edge   = (dial_en != prev_en_q);
		idle_n    = (idle_q == IDLE_MAX) ? idle_q : idle_q + 1'b1;
		if (en_edge) begin
			idle_n = '0;
		end
		start  = en_edge && (dial_en == ~cfg.enable_inverse) && !dialing_q;
		commit = en_edge && (dial_en == cfg.enable_inverse);
		room   = (count_x < limit_x);
		dial_n   = dialing_q || start;
		pcnt_mid = (start || commit) ? '0 : pcnt_q;
		count_n  = (commit && room) ? count_q + 1'b1 : count_q;
		count_n_x = CMP_W'(count_n);
		report = dial_n && ((idle_n >= cfg.waiting_time_ms) || (count_n_x >= limit_x))
			&& (dial_en == cfg.enable_inverse);
		pcnt_n = pcnt_mid;
		deb_n  = deb_q;
		if (deb_q != '0) begin
			deb_n = deb_q - 1'b1;
		end else if ((pulse_level == cfg.pulse_inverse) && (prev_pul_q != cfg.pulse_inverse)) begin
			if (pcnt_mid != PCNT_MAX) begin
				pcnt_n = pcnt_mid + 1'b1;
			end
			deb_n = cfg.debounce_ms;
		end
	end

	assign st_we    = accept && (kind == KIND_TICK) && commit && room;
	assign st_waddr = count_q[AW-1:0];
	assign st_wdata = (pcnt_q >= DIGIT_BASE) ? '0 : pcnt_q[DIGIT_W-1:0];
	assign st_raddr = k_q[AW-1:0];

	assign k_x      = CMP_W'(k_q);
	assign k_inc    = k_q + 1'b1;
	assign k_last   = (k_inc == emit_n_q);
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_en_q   <= 1'b0;
			prev_pul_q  <= 1'b1;
			dialing_q   <= 1'b0;
			pcnt_q      <= '0;
			count_q     <= '0;
			idle_q      <= '0;
			deb_q       <= '0;
			emit_n_q    <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_LOAD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (kind == KIND_CLEAR) begin
							count_q   <= '0;
							dialing_q <= 1'b0;
							pcnt_q    <= '0;
						end else begin
							prev_en_q  <= dial_en;
							prev_pul_q <= pulse_level;
							idle_q     <= idle_n;
							pcnt_q     <= pcnt_n;
							deb_q      <= deb_n;
							if (report) begin
								count_q   <= '0;
								dialing_q <= 1'b0;
								emit_n_q  <= count_n;
								k_q       <= '0;
								if (count_n != '0) begin
									state_q <= ST_RD;
								end
							end else begin
								count_q   <= count_n;
								dialing_q <= dial_n;
							end
						end
					end
				end
				ST_RD: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						k_q     <= k_inc;
						state_q <= k_last ? ST_IDLE : ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && out_free) begin
			digit_q <= st_rdata;
			pos_q   <= k_x[POS_W-1:0];
			last_q  <= k_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign digit          = digit_q;
	assign digit_position = pos_q;
	assign last_digit     = last_q;

endmodule

// ----- rtl/core/rotary_dial_pulse_decoder_top.sv -----
// Rotary dial pulse decoder: each input transfer is a one-millisecond sample tick of
// the dial's enable and pulse contacts, or a command that clears the number being
// dialed. Pulses are counted with a debounce hold-off, enable edges start a dial or
// commit a digit, and on idle timeout or a full number the digits go out one transfer
// each, first digit first, with last_digit on the final one. A tick or clear command
// is taken whenever the sequencer is idle; a tick that reports a number of n digits holds
// the input stalled until each digit has been read from the registered digit store and
// then loaded into the output register, which takes longer while the output stalls.
// Depends on rdpd_pkg, rdpd_regs, rdpd_store and rdpd_ctrl.
module rotary_dial_pulse_decoder_top import rdpd_pkg::*; #(
	parameter int MAX_DIGIT_STORE = DEF_MAX_DIGIT_STORE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  kind,
	input  logic                  enable_level,
	input  logic                  pulse_level,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DIGIT_W-1:0]    digit,
	output logic [POS_W-1:0]      digit_position,
	output logic                  last_digit,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CAP = (MAX_DIGIT_STORE < RESULT_LIMIT) ? MAX_DIGIT_STORE : RESULT_LIMIT;
	localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
	localparam int CW  = $clog2(CAP + 1);

	cfg_t               cfg;
	logic               st_we;
	logic [AW-1:0]      st_waddr;
	logic [DIGIT_W-1:0] st_wdata;
	logic [AW-1:0]      st_raddr;
	logic [DIGIT_W-1:0] st_rdata;

	assign cfg_ready = 1'b1;

	rdpd_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rdpd_store #(
		.DEPTH (CAP),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	rdpd_ctrl #(
		.CAP (CAP),
		.AW  (AW),
		.CW  (CW)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.enable_level   (enable_level),
		.pulse_level    (pulse_level),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.digit          (digit),
		.digit_position (digit_position),
		.last_digit     (last_digit),
		.st_we          (st_we),
		.st_waddr       (st_waddr),
		.st_wdata       (st_wdata),
		.st_raddr       (st_raddr),
		.st_rdata       (st_rdata)
	);

endmodule

// ----- bench/rotary_dial_pulse_decoder_top_test.sv -----
// Self-checking testbench for rotary_dial_pulse_decoder_top.
// It mirrors the decoder's tick-by-tick behavior, feeds directed and random
// dialing with random pacing on both sides, and checks every digit transfer.
// Depends on rdpd_pkg and the decoder RTL.
module rotary_dial_pulse_decoder_top_test;
	import rdpd_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int STORE_DEPTH = (DEF_MAX_DIGIT_STORE < RESULT_LIMIT) ?
		DEF_MAX_DIGIT_STORE : RESULT_LIMIT;
	localparam int DRAIN_CYCLES = 80;
	localparam int END_WAIT_LIMIT = 20000;
	localparam int LONG_HOLD = 400;
	localparam int RANDOM_ITEMS = 100;
	localparam longint RUN_LIMIT = 64'd60_000_000;
	localparam logic EN_DIALING = 1'b0;
	localparam logic EN_REST = 1'b1;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic [POS_W-1:0]   position;
		logic               last;
	} dial_digit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = KIND_TICK;
	logic enable_level = 1'b1;
	logic pulse_level = 1'b1;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [DIGIT_W-1:0] digit;
	logic [POS_W-1:0] digit_position;
	logic last_digit;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_WAITING_TIME;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	cfg_t cfg;
	logic en_state_seen;
	logic dialing;
	logic [PCNT_W-1:0] pulse_tally;
	logic [DIGIT_W-1:0] digits_held [STORE_DEPTH];
	logic [LIM_W-1:0] held_count;
	logic [WAIT_W-1:0] idle_ms;
	logic [DEB_W-1:0] holdoff_left;
	logic pulse_seen;

	dial_digit_t pending_digits [$];
	int mismatches = 0;
	int items_sent = 0;
	int digits_predicted = 0;
	int numbers_reported = 0;
	int reg_writes = 0;
	int long_holds = 0;
	int quiet_left = 0;
	bit hold_request = 1'b0;
	bit holding = 1'b0;

	rotary_dial_pulse_decoder_top i_dut (
		.clk, .arst_n, .in_valid, .in_stall, .kind, .enable_level, .pulse_level,
		.out_valid, .out_stall, .digit, .digit_position, .last_digit,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic int length_cap(input logic [LIM_W-1:0] m);
		if (m == 0)
			return 1;
		if (m > STORE_DEPTH)
			return STORE_DEPTH;
		return int'(m);
	endfunction

	function automatic int pick_gap();
		int roll;
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			quiet_left = $urandom_range(20, 60);
			return 0;
		end
		if (roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int pick_pulses();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 7)
			return $urandom_range(1, 5);
		if (roll < 9)
			return $urandom_range(6, 9);
		return $urandom_range(10, 12);
	endfunction

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("Mismatch: %s", what);
	endtask

	task automatic decode_sample(input logic k, input logic en, input logic pl);
		logic en_state;
		logic [DIGIT_W-1:0] committed;
		dial_digit_t d;
		int cap;
		cap = length_cap(cfg.max_digits);
		if (k == KIND_CLEAR) begin
			held_count = '0;
			dialing = 1'b0;
			pulse_tally = '0;
		end else begin
			if (idle_ms != IDLE_MAX)
				idle_ms = idle_ms + 1'b1;
			en_state = ~en ^ cfg.enable_inverse;
			if (en_state != en_state_seen) begin
				en_state_seen = en_state;
				idle_ms = '0;
				if (en_state == ~cfg.enable_inverse && !dialing) begin
					dialing = 1'b1;
					pulse_tally = '0;
				end else if (en_state == cfg.enable_inverse) begin
					committed = (pulse_tally >= DIGIT_BASE) ? '0 : pulse_tally[DIGIT_W-1:0];
					if (held_count < cap) begin
						digits_held[held_count] = committed;
						held_count = held_count + 1'b1;
					end
					pulse_tally = '0;
				end
			end
			if (dialing && (idle_ms >= cfg.waiting_time_ms || held_count >= cap) &&
					en_state == cfg.enable_inverse) begin
				for (int i = 0; i < held_count; i++) begin
					d.digit = digits_held[i];
					d.position = i[POS_W-1:0];
					d.last = (i + 1 == held_count);
					pending_digits.push_back(d);
					digits_predicted++;
				end
				if (held_count != 0)
					numbers_reported++;
				held_count = '0;
				dialing = 1'b0;
			end
			if (holdoff_left != 0) begin
				holdoff_left = holdoff_left - 1'b1;
			end else if (pl == cfg.pulse_inverse && pulse_seen != cfg.pulse_inverse) begin
				if (pulse_tally != PCNT_MAX)
					pulse_tally = pulse_tally + 1'b1;
				holdoff_left = cfg.debounce_ms;
			end
			pulse_seen = pl;
		end
	endtask

	task automatic send_sample(input logic k, input logic en, input logic pl);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		enable_level <= en;
		pulse_level <= pl;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		decode_sample(k, en, pl);
	endtask

	task automatic send_noise(input int count);
		repeat (count)
			send_sample(($urandom_range(0, 5) == 0) ? KIND_CLEAR : KIND_TICK,
				$urandom_range(0, 1), $urandom_range(0, 1));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (index)
			REG_WAITING_TIME: cfg.waiting_time_ms = value[WAIT_W-1:0];
			REG_MAX_DIGITS:   cfg.max_digits = value[LIM_W-1:0];
			REG_ENABLE_INV:   cfg.enable_inverse = value[0];
			REG_PULSE_INV:    cfg.pulse_inverse = value[0];
			REG_DEBOUNCE:     cfg.debounce_ms = value[DEB_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic set_config(input int unsigned wait_ms, input int unsigned max_len,
			input int unsigned en_inv, input int unsigned pul_inv, input int unsigned deb);
		drain_results();
		write_reg(REG_WAITING_TIME, wait_ms);
		write_reg(REG_MAX_DIGITS, max_len);
		write_reg(REG_ENABLE_INV, en_inv);
		write_reg(REG_PULSE_INV, pul_inv);
		write_reg(REG_DEBOUNCE, deb);
	endtask

	// One turn of the dial: enable goes active, pulses with hold-off spacing, enable rests.
	task automatic dial_digit(input int pulse_total, input bit bouncy);
		logic idle_pl;
		idle_pl = ~cfg.pulse_inverse;
		repeat ($urandom_range(1, 2)) send_sample(KIND_TICK, EN_DIALING, idle_pl);
		for (int p = 0; p < pulse_total; p++) begin
			repeat ($urandom_range(1, 2)) send_sample(KIND_TICK, EN_DIALING, ~idle_pl);
			repeat (cfg.debounce_ms + $urandom_range(0, 1))
				send_sample(KIND_TICK, EN_DIALING,
					(bouncy && $urandom_range(0, 9) == 0) ? ~idle_pl : idle_pl);
			send_sample(KIND_TICK, EN_DIALING, idle_pl);
		end
		send_sample(KIND_TICK, EN_REST, idle_pl);
	endtask

	task automatic dial_number(input int digits_wanted);
		for (int n = 0; n < digits_wanted; n++)
			dial_digit(pick_pulses(), 1'b1);
		if (cfg.waiting_time_ms <= 16'd64)
			repeat (cfg.waiting_time_ms + $urandom_range(0, 2))
				send_sample(KIND_TICK, EN_REST, ~cfg.pulse_inverse);
	endtask

	task automatic test_dial_and_clear();
		set_config(2, 3, 0, 0, 1);
		send_sample(KIND_TICK, 1'b0, 1'b1);
		send_sample(KIND_TICK, 1'b0, 1'b0);
		send_sample(KIND_TICK, 1'b0, 1'b1);
		send_sample(KIND_TICK, 1'b0, 1'b0);
		send_sample(KIND_TICK, 1'b1, 1'b1);
		send_sample(KIND_TICK, 1'b1, 1'b1);
		send_sample(KIND_TICK, 1'b1, 1'b1);
		send_sample(KIND_CLEAR, 1'b0, 1'b0);
		send_sample(KIND_TICK, 1'b0, 1'b1);
		send_sample(KIND_CLEAR, 1'b1, 1'b1);
		send_sample(KIND_TICK, 1'b1, 1'b1);
		send_sample(KIND_TICK, 1'b0, 1'b1);
		send_sample(KIND_TICK, 1'b1, 1'b1);
		send_sample(KIND_TICK, 1'b1, 1'b1);
		send_sample(KIND_TICK, 1'b1, 1'b1);
		repeat (3) begin
			send_sample(KIND_TICK, 1'b0, 1'b1);
			send_sample(KIND_TICK, 1'b1, 1'b1);
		end
	endtask

	task automatic test_pulse_count_limits();
		set_config(3, 2, 0, 0, 1);
		dial_digit(10, 1'b0);
		dial_digit(12, 1'b0);
	endtask

	task automatic test_length_limits();
		set_config(60000, 0, 0, 0, 1);
		dial_digit(3, 1'b0);
		set_config(60000, 4, 0, 0, 1);
		repeat (3) dial_digit($urandom_range(1, 3), 1'b0);
		drain_results();
		write_reg(REG_MAX_DIGITS, 2);
		dial_digit(2, 1'b0);
	endtask

	task automatic test_empty_number();
		set_config(1, 4, 0, 0, 1);
		send_sample(KIND_TICK, EN_DIALING, 1'b1);
		drain_results();
		write_reg(REG_ENABLE_INV, 1);
		send_sample(KIND_TICK, EN_REST, 1'b1);
		dial_digit(2, 1'b0);
		send_sample(KIND_TICK, EN_REST, 1'b1);
	endtask

	task automatic test_output_backpressure();
		set_config(60000, 63, 0, 1, 1);
		repeat (STORE_DEPTH - 1) dial_digit($urandom_range(0, 1), 1'b1);
		in_valid <= 1'b0;
		hold_request = 1'b1;
		wait (holding);
		dial_digit($urandom_range(1, 2), 1'b0);
		repeat (10) send_sample(KIND_TICK, EN_REST, ~cfg.pulse_inverse);
	endtask

	task automatic test_random_dialing();
		int items_at_start;
		int roll;
		int wait_ms;
		int max_len;
		int longest;
		items_at_start = items_sent;
		while (items_sent - items_at_start < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 9);
			wait_ms = (roll == 0) ? 1 : (roll == 1) ? 60000 : $urandom_range(2, 10);
			roll = $urandom_range(0, 9);
			max_len = (roll == 0) ? 1 : (roll == 1) ? 32 : $urandom_range(2, 6);
			if (wait_ms == 60000 && max_len == 32)
				max_len = 3;
			set_config(wait_ms, max_len, $urandom_range(0, 1), $urandom_range(0, 1),
				$urandom_range(1, 4));
			longest = (length_cap(cfg.max_digits) < 6) ? length_cap(cfg.max_digits) + 1 : 6;
			repeat ($urandom_range(1, 3)) begin
				roll = $urandom_range(0, 9);
				if (roll < 7) begin
					dial_number($urandom_range(1, longest));
				end else if (roll < 9) begin
					send_noise($urandom_range(3, 12));
				end else begin
					dial_digit(pick_pulses(), 1'b1);
					send_sample(KIND_CLEAR, $urandom_range(0, 1), $urandom_range(0, 1));
				end
			end
		end
	endtask

	// Pulses that come inside the long hold-off are ignored.
	task automatic test_slow_settings();
		set_config(60000, 1, 0, 0, 1000);
		send_sample(KIND_TICK, EN_DIALING, 1'b1);
		send_sample(KIND_TICK, EN_DIALING, 1'b0);
		repeat (3) begin
			send_sample(KIND_TICK, EN_DIALING, 1'b1);
			send_sample(KIND_TICK, EN_DIALING, 1'b0);
		end
		send_sample(KIND_TICK, EN_REST, 1'b1);
	endtask

	initial begin
		int unsigned span;
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				holding = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				holding = 1'b0;
				long_holds++;
			end else begin
				out_stall <= ($urandom_range(0, 3) == 0);
				span = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) :
					$urandom_range(1, 3);
				repeat (span) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		dial_digit_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_digits.size() == 0) begin
				note_mismatch($sformatf("unexpected digit %0d at position %0d",
					digit, digit_position));
			end else begin
				want = pending_digits.pop_front();
				if (digit !== want.digit)
					note_mismatch($sformatf("digit at position %0d: expected %0d, got %0d",
						want.position, want.digit, digit));
				if (digit_position !== want.position)
					note_mismatch($sformatf("digit_position: expected %0d, got %0d",
						want.position, digit_position));
				if (last_digit !== want.last)
					note_mismatch($sformatf("last_digit at position %0d: expected %0d, got %0d",
						want.position, want.last, last_digit));
			end
		end
	end

	initial begin
		#RUN_LIMIT;
		$display("Run timed out with %0d digits still expected.", pending_digits.size());
		$display("FAILURE");
		$finish;
	end

	initial begin
		int waited;
		cfg.waiting_time_ms = RST_WAITING_TIME;
		cfg.max_digits = RST_MAX_DIGITS;
		cfg.enable_inverse = 1'b0;
		cfg.pulse_inverse = 1'b0;
		cfg.debounce_ms = RST_DEBOUNCE;
		en_state_seen = 1'b0;
		dialing = 1'b0;
		pulse_tally = '0;
		held_count = '0;
		idle_ms = '0;
		holdoff_left = '0;
		pulse_seen = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_dial_and_clear();
		test_pulse_count_limits();
		test_length_limits();
		test_empty_number();
		test_output_backpressure();
		test_random_dialing();
		test_slow_settings();

		in_valid <= 1'b0;
		waited = 0;
		while (pending_digits.size() != 0 && waited < END_WAIT_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_digits.size() != 0)
			note_mismatch($sformatf("%0d expected digits never arrived",
				pending_digits.size()));
		$display("Covered %0d input transfers and %0d digits in %0d reported numbers.",
			items_sent, digits_predicted, numbers_reported);
		$display("Used %0d register writes and %0d long output holds; %0d mismatches.",
			reg_writes, long_holds, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/rdpd_pkg.sv
rtl/core/rdpd_regs.sv
rtl/core/rdpd_store.sv
rtl/core/rdpd_ctrl.sv
rtl/core/rotary_dial_pulse_decoder_top.sv
bench/rotary_dial_pulse_decoder_top_test.sv
